// ===== src/uvsg_pkg.sv =====
// Shared constants, types and tables for the UV-sphere vertex generator.
// No dependencies.
`default_nettype none

package uvsg_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int MAX_COUNT_DEF     = 1024;

    // divider geometry: remainder holds a count, quotient covers 0..2*pi in Q3.30
    localparam int DIV_RW = 11;
    localparam int DIV_QW = 33;
    localparam int DIV_NW = DIV_RW + DIV_QW;

    localparam logic [31:0] PI_Q30      = 32'd3373259426;
    localparam logic [32:0] TWO_PI_Q30  = 33'd6746518852;
    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic [31:0] GAIN_Q30    = 32'd652032874;

    localparam int ATAN_LEN = 24;

    // register index codes (paddr[3:2])
    localparam logic [1:0] REG_RADIUS  = 2'd0;
    localparam logic [1:0] REG_RINGS   = 2'd1;
    localparam logic [1:0] REG_SEGS    = 2'd2;

    typedef struct packed {
        logic oor;
        logic top;
        logic bot;
    } flags_t;

    typedef struct packed {
        logic [16:0]        tex_u;
        logic [16:0]        tex_v;
    } tex_t;

    typedef struct packed {
        logic               oor;
        logic [16:0]        tex_v;
        logic [16:0]        tex_u;
        logic signed [15:0] tangent_z;
        logic signed [15:0] tangent_x;
        logic signed [15:0] normal_z;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_x;
        logic signed [16:0] pos_z;
        logic signed [16:0] pos_y;
        logic signed [16:0] pos_x;
    } vtx_t;

    // atan(2^-i) in Q2.30
    function automatic logic [31:0] atan_q30(input int i);
        logic [31:0] r;
        case (i)
            0:       r = 32'd843314856;
            1:       r = 32'd497837829;
            2:       r = 32'd263043836;
            3:       r = 32'd133525158;
            4:       r = 32'd67021686;
            5:       r = 32'd33543515;
            6:       r = 32'd16775850;
            7:       r = 32'd8388437;
            8:       r = 32'd4194282;
            9:       r = 32'd2097149;
            10:      r = 32'd1048575;
            11:      r = 32'd524287;
            12:      r = 32'd262143;
            13:      r = 32'd131071;
            14:      r = 32'd65535;
            15:      r = 32'd32767;
            16:      r = 32'd16383;
            17:      r = 32'd8191;
            18:      r = 32'd4095;
            19:      r = 32'd2047;
            20:      r = 32'd1023;
            21:      r = 32'd511;
            22:      r = 32'd255;
            23:      r = 32'd127;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/uv_sphere_vertex_generator.sv =====
// UV-sphere vertex generator: dividers, angle fold, two CORDICs, products.
// Depends on uvsg_pkg and uvsg_div.
//
//  channel   dir  handshake                  payload
//  s_*       in   s_tvalid / s_tready        s_tdata: ring, segment
//  m_*       out  m_tvalid / m_tready        m_tdata: vertex, m_tuser: out_of_range
//  APB       in   psel/penable/pwrite/pready sphere_radius, ring_count, segment_count
//
// One request per cycle while the skid register is empty. Stages: input register,
// 33 divider stages, fold, CORDIC_STAGES rotations, sign fix, four product
// and rounding stages, then the output register. Reset clears the valid bits
// and loads the configuration registers with their defaults. On a stall a skid
// register catches one result, then the whole pipeline holds.
`default_nettype none

module uv_sphere_vertex_generator
    import uvsg_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
    parameter int MAX_COUNT     = MAX_COUNT_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [23:0]  s_tdata,   // ring[10:0], segment[21:11]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [167:0]      m_tdata,   // pos_x, pos_y, pos_z, normal_x/y/z,
                                         // tangent_x, tangent_z, tex_u, tex_v
    output logic              m_tuser,   // out_of_range
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int CS     = CORDIC_STAGES;
    localparam int NST    = CS + 40;
    localparam int FOLD   = DIV_QW + 1;
    localparam int NEG    = FOLD + CS + 1;
    localparam int TEXL   = NST - FOLD;

    localparam logic signed [34:0] PI_S      = 35'(PI_Q30);
    localparam logic signed [34:0] TWO_PI_S  = 35'(TWO_PI_Q30);
    localparam logic signed [34:0] HALF_PI_S = 35'(HALF_PI_Q30);

    // ---------------- configuration ----------------
    logic [15:0] radius_reg;
    logic [10:0] rings_reg;
    logic [10:0] segs_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 16'd256;
            rings_reg  <= 11'd8;
            segs_reg   <= 11'd8;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                REG_RADIUS: radius_reg <= pwdata[15:0];
                REG_RINGS:  rings_reg  <= pwdata[10:0];
                REG_SEGS:   segs_reg   <= pwdata[10:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_RADIUS: prdata = {16'd0, radius_reg};
            REG_RINGS:  prdata = {21'd0, rings_reg};
            REG_SEGS:   prdata = {21'd0, segs_reg};
            default:    prdata = 32'd0;
        endcase
    end

    // ---------------- stall control ----------------
    logic en;
    logic v_reg [0:NST-1];
    logic skid_v_reg;
    logic out_v_reg;

    assign en       = !skid_v_reg;
    assign s_tready = en;

    // ---------------- input stage ----------------
    logic [10:0] ring_in;
    logic [10:0] seg_in;
    logic        bad_cfg;
    flags_t      flags_next;
    flags_t      flags_reg [0:NST-1];
    logic [DIV_NW-1:0] num_phi_reg, num_th_reg, num_u_reg, num_v_reg;

    assign ring_in = s_tdata[10:0];
    assign seg_in  = s_tdata[21:11];

    always_comb
    begin
        logic ring_bad;
        logic pole;
        bad_cfg = (rings_reg == 11'd0) || (segs_reg == 11'd0) ||
                  (32'(rings_reg) > 32'(MAX_COUNT)) || (32'(segs_reg) > 32'(MAX_COUNT));
        ring_bad = bad_cfg || (ring_in > rings_reg);
        pole     = (ring_in == 11'd0) || (ring_in == rings_reg);
        flags_next.top = !ring_bad && (ring_in == 11'd0);
        flags_next.bot = !ring_bad && (ring_in != 11'd0) && (ring_in == rings_reg);
        flags_next.oor = ring_bad || (!pole && (seg_in > segs_reg));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_phi_reg <= DIV_NW'(ring_in) * DIV_NW'(PI_Q30);
            num_th_reg  <= DIV_NW'(seg_in) * DIV_NW'(TWO_PI_Q30);
            num_u_reg   <= {17'd0, seg_in, 16'd0};
            num_v_reg   <= {17'd0, ring_in, 16'd0};
            flags_reg[0] <= flags_next;
            for (int k = 1; k < NST; k++)
                flags_reg[k] <= flags_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NST; k++)
                v_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= s_tvalid;
            for (int k = 1; k < NST; k++)
                v_reg[k] <= v_reg[k-1];
        end
    end

    // ---------------- dividers ----------------
    logic [DIV_QW-1:0] phi_q, th_q, u_q, vq_q;

    uvsg_div #(.RW(DIV_RW), .QW(DIV_QW)) u_div_phi
    (
        .clk(clk), .en(en), .num(num_phi_reg), .den(rings_reg), .quo(phi_q)
    );
    uvsg_div #(.RW(DIV_RW), .QW(DIV_QW)) u_div_th
    (
        .clk(clk), .en(en), .num(num_th_reg), .den(segs_reg), .quo(th_q)
    );
    uvsg_div #(.RW(DIV_RW), .QW(DIV_QW)) u_div_u
    (
        .clk(clk), .en(en), .num(num_u_reg), .den(segs_reg), .quo(u_q)
    );
    uvsg_div #(.RW(DIV_RW), .QW(DIV_QW)) u_div_v
    (
        .clk(clk), .en(en), .num(num_v_reg), .den(rings_reg), .quo(vq_q)
    );

    // texture coordinates ride alongside the angle path
    tex_t tex_reg [0:TEXL-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tex_reg[0].tex_u <= u_q[16:0];
            tex_reg[0].tex_v <= vq_q[16:0];
            for (int k = 1; k < TEXL; k++)
                tex_reg[k] <= tex_reg[k-1];
        end
    end

    // ---------------- angle fold ----------------
    function automatic logic [34:0] fold(input logic [DIV_QW-1:0] q);
        logic signed [34:0] a;
        logic               neg;
        a   = $signed({2'b00, q});
        neg = 1'b0;
        if (a > PI_S)
            a = a - TWO_PI_S;
        if (a > HALF_PI_S)
        begin
            a   = a - PI_S;
            neg = 1'b1;
        end
        else if (a < -HALF_PI_S)
        begin
            a   = a + PI_S;
            neg = 1'b1;
        end
        return {neg, a[33:0]};
    endfunction

    logic signed [33:0] xp_reg [0:CS], yp_reg [0:CS], zp_reg [0:CS];
    logic signed [33:0] xt_reg [0:CS], yt_reg [0:CS], zt_reg [0:CS];
    logic               negp_reg [0:CS], negt_reg [0:CS];

    always_ff @(posedge clk)
    begin
        logic [34:0] fp, ft;
        fp = fold(phi_q);
        ft = fold(th_q);
        if (en)
        begin
            xp_reg[0]   <= 34'(GAIN_Q30);
            yp_reg[0]   <= 34'sd0;
            zp_reg[0]   <= fp[33:0];
            negp_reg[0] <= fp[34];
            xt_reg[0]   <= 34'(GAIN_Q30);
            yt_reg[0]   <= 34'sd0;
            zt_reg[0]   <= ft[33:0];
            negt_reg[0] <= ft[34];
        end
    end

    // ---------------- CORDIC rotations ----------------
    genvar gi;
    generate
        for (gi = 0; gi < CS; gi++)
        begin : g_cordic
            localparam logic signed [33:0] ATAN_I = 34'(atan_q30(gi));
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (zp_reg[gi] >= 0)
                    begin
                        xp_reg[gi+1] <= xp_reg[gi] - (yp_reg[gi] >>> gi);
                        yp_reg[gi+1] <= yp_reg[gi] + (xp_reg[gi] >>> gi);
                        zp_reg[gi+1] <= zp_reg[gi] - ATAN_I;
                    end
                    else
                    begin
                        xp_reg[gi+1] <= xp_reg[gi] + (yp_reg[gi] >>> gi);
                        yp_reg[gi+1] <= yp_reg[gi] - (xp_reg[gi] >>> gi);
                        zp_reg[gi+1] <= zp_reg[gi] + ATAN_I;
                    end
                    if (zt_reg[gi] >= 0)
                    begin
                        xt_reg[gi+1] <= xt_reg[gi] - (yt_reg[gi] >>> gi);
                        yt_reg[gi+1] <= yt_reg[gi] + (xt_reg[gi] >>> gi);
                        zt_reg[gi+1] <= zt_reg[gi] - ATAN_I;
                    end
                    else
                    begin
                        xt_reg[gi+1] <= xt_reg[gi] + (yt_reg[gi] >>> gi);
                        yt_reg[gi+1] <= yt_reg[gi] - (xt_reg[gi] >>> gi);
                        zt_reg[gi+1] <= zt_reg[gi] + ATAN_I;
                    end
                    negp_reg[gi+1] <= negp_reg[gi];
                    negt_reg[gi+1] <= negt_reg[gi];
                end
            end
        end
    endgenerate

    // ---------------- sign fix, products, rounding ----------------
    logic signed [31:0] sp_reg, cp_reg, st_reg, ct_reg;
    logic signed [63:0] phx_reg, phz_reg;
    logic signed [31:0] cp1_reg, st1_reg, ct1_reg;
    logic signed [33:0] hx_reg, hz_reg;
    logic signed [31:0] cp2_reg, st2_reg, ct2_reg;
    logic signed [50:0] prx_reg, pry_reg, prz_reg;
    logic signed [15:0] nx_reg, ny_reg, nz_reg, tx_reg, tz_reg;
    vtx_t               fin_reg;
    vtx_t               fin_next;

    function automatic logic signed [15:0] rnd_sat16(input logic signed [33:0] v);
        logic signed [34:0] t;
        logic signed [18:0] q;
        t = 35'(v) + 35'sd32768;
        q = 19'(t >>> 16);
        if (q > 19'sd16384)
            return 16'sd16384;
        else if (q < -19'sd16384)
            return -16'sd16384;
        else
            return q[15:0];
    endfunction

    function automatic logic signed [16:0] rnd_sat17(input logic signed [50:0] v);
        logic signed [51:0] t;
        logic signed [21:0] q;
        t = 52'(v) + 52'sd536870912;
        q = 22'(t >>> 30);
        if (q > 22'sd65535)
            return 17'sd65535;
        else if (q < -22'sd65535)
            return -17'sd65535;
        else
            return q[16:0];
    endfunction

    always_ff @(posedge clk)
    begin
        logic signed [64:0] thx, thz;
        logic signed [16:0] rs;
        if (en)
        begin
            // undo the fold
            sp_reg <= negp_reg[CS] ? -yp_reg[CS][31:0] : yp_reg[CS][31:0];
            cp_reg <= negp_reg[CS] ? -xp_reg[CS][31:0] : xp_reg[CS][31:0];
            st_reg <= negt_reg[CS] ? -yt_reg[CS][31:0] : yt_reg[CS][31:0];
            ct_reg <= negt_reg[CS] ? -xt_reg[CS][31:0] : xt_reg[CS][31:0];

            phx_reg <= sp_reg * ct_reg;
            phz_reg <= sp_reg * st_reg;
            cp1_reg <= cp_reg;
            st1_reg <= st_reg;
            ct1_reg <= ct_reg;

            thx = 65'(phx_reg) + 65'sd536870912;
            thz = 65'(phz_reg) + 65'sd536870912;
            hx_reg  <= 34'(thx >>> 30);
            hz_reg  <= 34'(thz >>> 30);
            cp2_reg <= cp1_reg;
            st2_reg <= st1_reg;
            ct2_reg <= ct1_reg;

            rs = $signed({1'b0, radius_reg});
            prx_reg <= 51'(rs * hx_reg);
            pry_reg <= 51'(rs * 34'(cp2_reg));
            prz_reg <= 51'(rs * hz_reg);
            nx_reg  <= rnd_sat16(hx_reg);
            ny_reg  <= rnd_sat16(34'(cp2_reg));
            nz_reg  <= rnd_sat16(hz_reg);
            tx_reg  <= rnd_sat16(-34'(st2_reg));
            tz_reg  <= rnd_sat16(34'(ct2_reg));

            fin_reg <= fin_next;
        end
    end

    // final select: poles and rejected requests override the datapath
    always_comb
    begin
        flags_t f;
        tex_t   tx;
        logic signed [16:0] rs;
        f  = flags_reg[NST-2];
        tx = tex_reg[TEXL-2];
        rs = $signed({1'b0, radius_reg});
        fin_next = '0;
        if (f.oor)
            fin_next.oor = 1'b1;
        else if (f.top)
        begin
            fin_next.pos_y     = rs;
            fin_next.normal_y  = 16'sd16384;
            fin_next.tangent_x = 16'sd16384;
        end
        else if (f.bot)
        begin
            fin_next.pos_y     = -rs;
            fin_next.normal_y  = -16'sd16384;
            fin_next.tangent_x = -16'sd16384;
            fin_next.tex_v     = 17'd65536;
        end
        else
        begin
            fin_next.pos_x     = rnd_sat17(prx_reg);
            fin_next.pos_y     = rnd_sat17(pry_reg);
            fin_next.pos_z     = rnd_sat17(prz_reg);
            fin_next.normal_x  = nx_reg;
            fin_next.normal_y  = ny_reg;
            fin_next.normal_z  = nz_reg;
            fin_next.tangent_x = tx_reg;
            fin_next.tangent_z = tz_reg;
            fin_next.tex_u     = tx.tex_u;
            fin_next.tex_v     = tx.tex_v;
        end
    end

    // ---------------- output register and skid ----------------
    vtx_t out_reg;
    vtx_t skid_reg;
    logic leaving;

    assign leaving = en && v_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (!out_v_reg || m_tready)
        begin
            if (skid_v_reg)
            begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end
            else
                out_v_reg <= leaving;
        end
        else if (leaving)
            skid_v_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_v_reg || m_tready)
            out_reg <= skid_v_reg ? skid_reg : fin_reg;
        else if (leaving)
            skid_reg <= fin_reg;
    end

    assign m_tvalid = out_v_reg;
    assign m_tuser  = out_reg.oor;
    assign m_tdata  = {3'b000, out_reg.tex_v, out_reg.tex_u, out_reg.tangent_z,
                       out_reg.tangent_x, out_reg.normal_z, out_reg.normal_y,
                       out_reg.normal_x, out_reg.pos_z, out_reg.pos_y, out_reg.pos_x};

endmodule

`default_nettype wire

// ===== src/uvsg_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Depends on uvsg_pkg. Numerator must satisfy num >> QW < den.
`default_nettype none

module uvsg_div
    import uvsg_pkg::*;
#(
    parameter int RW = DIV_RW,
    parameter int QW = DIV_QW
)
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic [RW+QW-1:0]   num,
    input  wire logic [RW-1:0]      den,
    output logic      [QW-1:0]      quo
);

    // upper RW bits: partial remainder; lower QW bits: numerator tail / quotient
    logic [RW+QW-1:0] s_reg  [0:QW-1];
    logic [RW+QW-1:0] s_next [0:QW-1];

    function automatic logic [RW+QW-1:0] step(input logic [RW+QW-1:0] s,
                                                input logic [RW-1:0] d);
        logic [RW:0]   t;
        logic [RW:0]   diff;
        logic [RW-1:0] rem;
        logic          q;
        t    = s[RW+QW-1:QW-1];
        diff = t - {1'b0, d};
        q    = (t >= {1'b0, d});
        rem  = q ? diff[RW-1:0] : t[RW-1:0];
        return {rem, s[QW-2:0], q};
    endfunction

    always_comb
    begin
        for (int k = 0; k < QW; k++)
        begin
            if (k == 0)
                s_next[k] = step(num, den);
            else
                s_next[k] = step(s_reg[k-1], den);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < QW; k++)
                s_reg[k] <= s_next[k];
        end
    end

    assign quo = s_reg[QW-1][QW-1:0];

endmodule

`default_nettype wire

// ===== tb/uv_sphere_vertex_generator_tb.sv =====
// Testbench for the UV-sphere vertex generator: directed table then random requests,
// checked against an in-bench CORDIC predictor. Depends on uvsg_pkg and the RTL.
`timescale 1ns / 100ps

module uv_sphere_vertex_generator_tb
    import uvsg_pkg::*;
();

    localparam int NUM_RANDOM = 1650;
    localparam int LATENCY    = 60;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        logic [10:0] ring;
        logic [10:0] segment;
        logic        known;     // expected vertex typed in below
        vtx_t        vtx;
    } dir_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [23:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [167:0] m_tdata;
    logic         m_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [3:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    vtx_t   expected_vertices[$];
    int     errors;
    longint cycles;
    bit     hold_off_req;
    logic [15:0] cur_radius;
    logic [10:0] cur_rings;
    logic [10:0] cur_segs;
    dir_row_t dir_rows[$];

    uv_sphere_vertex_generator uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic longint atan_tab(input int i);
        longint t[24] = '{843314856, 497837829, 263043836, 133525158, 67021686,
            33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287,
            262143, 131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511,
            255, 127};
        return t[i];
    endfunction

    function automatic longint round_shift(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint sat(input longint v, input longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    // rotation-mode CORDIC on a Q3.30 angle in 0..2*pi
    task automatic rotate_angle(input longint a, output longint sn, output longint cs);
        longint pi_v, x, y, z, dx, dy;
        bit     flip;
        pi_v = longint'(PI_Q30);
        flip = 1'b0;
        x = longint'(GAIN_Q30);
        y = 0;
        if (a > pi_v)
            a -= 2 * pi_v;
        if (a > pi_v / 2)
        begin
            a -= pi_v;
            flip = 1'b1;
        end
        else if (a < -(pi_v / 2))
        begin
            a += pi_v;
            flip = 1'b1;
        end
        z = a;
        for (int i = 0; i < CORDIC_STAGES_DEF; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= atan_tab(i);
            end
            else
            begin
                x += dx; y -= dy; z += atan_tab(i);
            end
        end
        sn = flip ? -y : y;
        cs = flip ? -x : x;
    endtask

    task automatic predict_vertex(input logic [10:0] ring, input logic [10:0] seg,
                                  output vtx_t v);
        longint r, rc, sc, phi, th, sp, cp, st, ct, hx, hz, pi_v;
        bit bad_cfg;
        r = cur_radius;
        rc = cur_rings;
        sc = cur_segs;
        pi_v = longint'(PI_Q30);
        bad_cfg = rc == 0 || sc == 0 || rc > MAX_COUNT_DEF || sc > MAX_COUNT_DEF;
        v = '0;
        if (bad_cfg || ring > rc)
            v.oor = 1'b1;
        else if (ring == 0 || ring == rc)
        begin
            v.pos_y    = 17'((ring == 0) ? r : -r);
            v.normal_y = (ring == 0) ? 16384 : -16384;
            v.tangent_x = (ring == 0) ? 16384 : -16384;
            v.tex_v    = (ring == 0) ? 0 : 65536;
        end
        else if (seg > sc)
            v.oor = 1'b1;
        else
        begin
            phi = (longint'(ring) * pi_v) / rc;
            th  = (longint'(seg) * 2 * pi_v) / sc;
            rotate_angle(phi, sp, cp);
            rotate_angle(th, st, ct);
            hx = round_shift(sp * ct, 30);
            hz = round_shift(sp * st, 30);
            v.pos_x     = 17'(sat(round_shift(r * hx, 30), 65535));
            v.pos_y     = 17'(sat(round_shift(r * cp, 30), 65535));
            v.pos_z     = 17'(sat(round_shift(r * hz, 30), 65535));
            v.normal_x  = 16'(sat(round_shift(hx, 16), 16384));
            v.normal_y  = 16'(sat(round_shift(cp, 16), 16384));
            v.normal_z  = 16'(sat(round_shift(hz, 16), 16384));
            v.tangent_x = 16'(sat(round_shift(-st, 16), 16384));
            v.tangent_z = 16'(sat(round_shift(ct, 16), 16384));
            v.tex_u     = 17'((longint'(seg) << 16) / sc);
            v.tex_v     = 17'((longint'(ring) << 16) / rc);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_RADIUS: cur_radius = val[15:0];
            REG_RINGS:  cur_rings  = val[10:0];
            REG_SEGS:   cur_segs   = val[10:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic [15:0] rad, input logic [10:0] rings,
                                input logic [10:0] segs);
        while (expected_vertices.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
        write_reg(REG_RADIUS, {16'd0, rad});
        write_reg(REG_RINGS, {21'd0, rings});
        write_reg(REG_SEGS, {21'd0, segs});
    endtask

    // offer one request, hold until accepted; tvalid stays high for back-to-back
    task automatic send_request(input logic [10:0] ring, input logic [10:0] seg);
        vtx_t v;
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, seg, ring};
        predict_vertex(ring, seg, v);
        expected_vertices = {expected_vertices, v};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic idle_gap(input int n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic random_request();
        logic [10:0] ring, seg;
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            ring = 11'($urandom);
        else if (pick == 1)
            ring = (cur_rings < 11'd2047) ? cur_rings + 11'd1 : cur_rings;
        else if (pick == 2)
            ring = 11'd0;
        else if (pick == 3)
            ring = cur_rings;
        else
            ring = (cur_rings > 11'd1) ? 11'($urandom_range(1, cur_rings - 1)) : 11'd0;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            seg = 11'($urandom);
        else if (pick == 1)
            seg = (cur_segs < 11'd2047) ? cur_segs + 11'd1 : cur_segs;
        else
            seg = 11'($urandom_range(0, cur_segs));
        send_request(ring, seg);
    endtask

    task automatic random_phase(input int n);
        int burst;
        while (n > 0)
        begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && n > 0)
            begin
                random_request();
                burst--;
                n--;
            end
            if ($urandom_range(0, 2) != 0)
                idle_gap($urandom_range(1, 6));
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic add_row(input logic [10:0] ring, input logic [10:0] seg,
                           input bit known, input vtx_t v);
        dir_row_t row;
        row.ring = ring;
        row.segment = seg;
        row.known = known;
        row.vtx = v;
        dir_rows = {dir_rows, row};
    endtask

    // receiver stall pattern, with a long hold-off on request
    initial
    begin
        int mode;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_req)
            begin
                m_tready <= 1'b0;
                repeat (200) @(posedge clk);
                hold_off_req = 1'b0;
            end
            mode = $urandom_range(0, 9);
            if (mode < 4)
                m_tready <= 1'b1;
            else if (mode < 7)
                m_tready <= 1'($urandom_range(0, 1));
            else
                m_tready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        vtx_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = vtx_t'({m_tuser, m_tdata[164:0]});
            if (expected_vertices.size() == 0)
            begin
                $error("unexpected vertex result");
                errors++;
            end
            else
            begin
                want = expected_vertices.pop_front();
                if (got.pos_x !== want.pos_x)
                begin
                    $error("pos_x exp %0d got %0d", want.pos_x, got.pos_x); errors++;
                end
                if (got.pos_y !== want.pos_y)
                begin
                    $error("pos_y exp %0d got %0d", want.pos_y, got.pos_y); errors++;
                end
                if (got.pos_z !== want.pos_z)
                begin
                    $error("pos_z exp %0d got %0d", want.pos_z, got.pos_z); errors++;
                end
                if (got.normal_x !== want.normal_x)
                begin
                    $error("normal_x exp %0d got %0d", want.normal_x, got.normal_x);
                    errors++;
                end
                if (got.normal_y !== want.normal_y)
                begin
                    $error("normal_y exp %0d got %0d", want.normal_y, got.normal_y);
                    errors++;
                end
                if (got.normal_z !== want.normal_z)
                begin
                    $error("normal_z exp %0d got %0d", want.normal_z, got.normal_z);
                    errors++;
                end
                if (got.tangent_x !== want.tangent_x)
                begin
                    $error("tangent_x exp %0d got %0d", want.tangent_x, got.tangent_x);
                    errors++;
                end
                if (got.tangent_z !== want.tangent_z)
                begin
                    $error("tangent_z exp %0d got %0d", want.tangent_z, got.tangent_z);
                    errors++;
                end
                if (got.tex_u !== want.tex_u)
                begin
                    $error("tex_u exp %0d got %0d", want.tex_u, got.tex_u); errors++;
                end
                if (got.tex_v !== want.tex_v)
                begin
                    $error("tex_v exp %0d got %0d", want.tex_v, got.tex_v); errors++;
                end
                if (got.oor !== want.oor)
                begin
                    $error("out_of_range exp %0d got %0d", want.oor, got.oor); errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        vtx_t v;
        errors = 0;
        cycles = 0;
        hold_off_req = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cur_radius = 16'd256;
        cur_rings = 11'd8;
        cur_segs = 11'd8;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, reset configuration
        v = '0; v.pos_y = 256; v.normal_y = 16384; v.tangent_x = 16384;
        add_row(0, 0, 1'b1, v);                  // top pole
        add_row(0, 11'h7FF, 1'b1, v);            // top pole ignores segment
        v = '0; v.pos_y = -256; v.normal_y = -16384; v.tangent_x = -16384;
        v.tex_v = 65536;
        add_row(8, 5, 1'b1, v);                  // bottom pole
        v = '0; v.oor = 1'b1;
        add_row(9, 0, 1'b1, v);                  // ring past bottom
        add_row(11'h7FF, 11'h7FF, 1'b1, v);
        add_row(4, 9, 1'b1, v);                  // segment past seam
        add_row(4, 0, 1'b0, v);
        add_row(4, 8, 1'b0, v);                  // seam duplicate
        add_row(1, 1, 1'b0, v);
        add_row(7, 7, 1'b0, v);
        add_row(2, 3, 1'b0, v);
        add_row(6, 2, 1'b0, v);
        add_row(3, 6, 1'b0, v);
        add_row(5, 4, 1'b0, v);
        foreach (dir_rows[i])
        begin
            send_request(dir_rows[i].ring, dir_rows[i].segment);
            if (dir_rows[i].known)
                expected_vertices[expected_vertices.size() - 1] = dir_rows[i].vtx;
        end
        s_tvalid <= 1'b0;

        // max radius and max counts, all fields wide
        apply_config(16'hFFFF, 11'd1024, 11'd1024);
        send_request(1, 1);
        send_request(512, 256);
        send_request(1023, 1024);
        send_request(1024, 0);
        send_request(11'h7FF, 11'h7FF);
        s_tvalid <= 1'b0;
        random_phase(250);

        // smallest counts with zero radius, then two rings and a single segment
        apply_config(16'd0, 11'd1, 11'd1);
        random_phase(100);
        apply_config(16'd4096, 11'd2, 11'd1);
        random_phase(150);

        // invalid counts: everything rejected
        apply_config(16'd300, 11'd0, 11'd16);
        random_phase(40);
        apply_config(16'd300, 11'd1025, 11'd2047);
        random_phase(40);

        // long receiver hold-off while requests keep coming, then random configurations
        apply_config(16'd256, 11'd24, 11'd32);
        hold_off_req = 1'b1;
        random_phase(300);
        apply_config(16'($urandom), 11'($urandom_range(1, 1024)),
                     11'($urandom_range(1, 1024)));
        random_phase(400);
        apply_config(16'($urandom), 11'($urandom_range(1, 64)),
                     11'($urandom_range(1, 64)));
        random_phase(370);

        while (expected_vertices.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
